[sv/dbs_pkg.sv]
// Package with the request, result and register index types of the brightness scheduler.
package dbs_pkg;

   localparam int TIME_WIDTH  = 17;
   localparam int LIGHT_WIDTH = 12;
   localparam int DUTY_WIDTH  = 17;
   localparam int DOT_WIDTH   = 16;
   localparam int LAST_WIDTH  = 18;
   localparam int DIFF_WIDTH  = 19;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOT_INTERVAL   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIGIT_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIGHT_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SNAP_WINDOW    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAMP_STEP      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIGHT_OFFSET   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_DIGIT_DUTY = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_DIGIT_DUTY = 3'd7;

   localparam int WAVE_PERIOD   = 10000;
   localparam int WAVE_PERIODS  = 13;
   localparam int WRAP_SPAN     = 100000;
   localparam int WRAP_AHEAD    = 90000;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  now_ms;
      logic [LIGHT_WIDTH-1:0] light_level;
   } req_type;

   typedef struct packed {
      logic                  dot_valid;
      logic [DOT_WIDTH-1:0]  dot_duty;
      logic                  digit_valid;
      logic [DUTY_WIDTH-1:0] digit_duty;
      logic [DUTY_WIDTH-1:0] target_duty;
      logic                  ramping;
   } rsp_type;

endpackage

[sv/display_brightness_scheduler.sv]
// Top level of the display brightness scheduler with dot, digit and light tasks.
// A request is captured in the input register, and its result is then registered in
// the result register, from where it can be taken. One request is accepted every cycle
// while results are taken; a full result register with the result side stalled holds
// the input register and stalls the request side. Synchronous active-high reset loads
// the register defaults, zeroes the duties and makes the next request a first pass.
module display_brightness_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dbs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dbs_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dbs_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import dbs_pkg::*;

   logic [TIME_WIDTH-1:0]  dot_interval_ff;
   logic [TIME_WIDTH-1:0]  digit_interval_ff;
   logic [TIME_WIDTH-1:0]  light_interval_ff;
   logic [DUTY_WIDTH-1:0]  snap_window_ff;
   logic [DUTY_WIDTH-1:0]  ramp_step_ff;
   logic [LIGHT_WIDTH-1:0] light_offset_ff;
   logic [DUTY_WIDTH-1:0]  min_duty_ff;
   logic [DUTY_WIDTH-1:0]  max_duty_ff;

   logic                   in_valid_ff, in_valid_in;
   req_type                in_data_ff;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_data_ff, out_data_in;

   logic signed [LAST_WIDTH-1:0] last_dot_ff, last_dot_in;
   logic signed [LAST_WIDTH-1:0] last_digit_ff, last_digit_in;
   logic signed [LAST_WIDTH-1:0] last_light_ff, last_light_in;
   logic                   started_ff;
   logic [DUTY_WIDTH-1:0]  current_ff, current_in;
   logic [DUTY_WIDTH-1:0]  target_ff, target_in;
   logic                   ramp_ff, ramp_in;

   logic                   advance;
   logic                   accept;
   logic [DOT_WIDTH-1:0]   wave_duty;

   logic signed [DIFF_WIDTH-1:0] now_s;
   logic signed [DIFF_WIDTH-1:0] dot_u, digit_u, light_u;
   logic                   dot_run, digit_run, light_run;
   logic signed [DIFF_WIDTH-1:0] diff, adiff;
   logic [DUTY_WIDTH:0]    step_dn, step_up;
   logic [LIGHT_WIDTH:0]   light_raw;
   logic [LIGHT_WIDTH-1:0] light_adj;
   logic signed [DIFF_WIDTH-1:0] tgt;

   function automatic logic signed [DIFF_WIDTH-1:0] unwrap(
      input logic signed [LAST_WIDTH-1:0] last,
      input logic signed [DIFF_WIDTH-1:0] now
   );
      logic signed [DIFF_WIDTH-1:0] last_x;
      last_x = DIFF_WIDTH'(last);
      if (last_x - now >= DIFF_WIDTH'(WRAP_AHEAD)) begin
         return last_x - DIFF_WIDTH'(WRAP_SPAN);
      end
      return last_x;
   endfunction

   dbs_dot_wave u_dot_wave (
      .now_ms (in_data_ff.now_ms),
      .duty   (wave_duty)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in  = accept | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & rsp_stall);

      now_s   = DIFF_WIDTH'(signed'({2'b00, in_data_ff.now_ms}));
      dot_u   = unwrap(last_dot_ff, now_s);
      digit_u = unwrap(last_digit_ff, now_s);
      light_u = unwrap(last_light_ff, now_s);

      dot_run   = ~started_ff
                  | (now_s - dot_u >= signed'({2'b00, dot_interval_ff}));
      digit_run = ~started_ff | ramp_ff
                  | (now_s - digit_u >= signed'({2'b00, digit_interval_ff}));
      light_run = ~started_ff
                  | (now_s - light_u >= signed'({2'b00, light_interval_ff}));

      last_dot_in   = dot_run   ? LAST_WIDTH'(now_s) : LAST_WIDTH'(dot_u);
      last_digit_in = digit_run ? LAST_WIDTH'(now_s) : LAST_WIDTH'(digit_u);
      last_light_in = light_run ? LAST_WIDTH'(now_s) : LAST_WIDTH'(light_u);

      diff    = signed'({2'b00, target_ff}) - signed'({2'b00, current_ff});
      adiff   = diff[DIFF_WIDTH-1] ? -diff : diff;
      step_dn = {1'b0, current_ff} - {1'b0, ramp_step_ff};
      step_up = {1'b0, current_ff} + {1'b0, ramp_step_ff};
      current_in = current_ff;
      ramp_in    = ramp_ff;
      if (digit_run) begin
         if (adiff > signed'({2'b00, snap_window_ff})) begin
            ramp_in = 1'b1;
            if (target_ff < current_ff) begin
               current_in = step_dn[DUTY_WIDTH] ? '0 : step_dn[DUTY_WIDTH-1:0];
            end else begin
               current_in = step_up[DUTY_WIDTH] ? '1 : step_up[DUTY_WIDTH-1:0];
            end
         end else begin
            ramp_in    = 1'b0;
            current_in = target_ff;
         end
      end

      light_raw = {1'b0, in_data_ff.light_level} - {1'b0, light_offset_ff};
      light_adj = light_raw[LIGHT_WIDTH] ? '0 : light_raw[LIGHT_WIDTH-1:0];
      tgt = signed'({2'b00, max_duty_ff}) - signed'({2'b00, light_adj, 5'b00000});
      if (tgt < signed'({2'b00, min_duty_ff})) begin
         tgt = signed'({2'b00, min_duty_ff});
      end
      if (tgt > signed'({2'b00, max_duty_ff})) begin
         tgt = signed'({2'b00, max_duty_ff});
      end
      target_in = light_run ? DUTY_WIDTH'(tgt) : target_ff;

      out_data_in.dot_valid   = dot_run;
      out_data_in.dot_duty    = dot_run ? wave_duty : '0;
      out_data_in.digit_valid = digit_run;
      out_data_in.digit_duty  = current_in;
      out_data_in.target_duty = target_in;
      out_data_in.ramping     = ramp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         current_ff   <= '0;
         target_ff    <= '0;
         ramp_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            started_ff <= 1'b1;
            current_ff <= current_in;
            target_ff  <= target_in;
            ramp_ff    <= ramp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff   <= out_data_in;
         last_dot_ff   <= last_dot_in;
         last_digit_ff <= last_digit_in;
         last_light_ff <= last_light_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_interval_ff   <= 17'd100;
         digit_interval_ff <= 17'd6000;
         light_interval_ff <= 17'd2000;
         snap_window_ff    <= 17'd4000;
         ramp_step_ff      <= 17'd2000;
         light_offset_ff   <= 12'd1500;
         min_duty_ff       <= 17'd15000;
         max_duty_ff       <= 17'd80000;
      end else if (csr_valid & csr_ready) begin
         unique case (csr_index)
            CSR_DOT_INTERVAL:   dot_interval_ff   <= csr_data;
            CSR_DIGIT_INTERVAL: digit_interval_ff <= csr_data;
            CSR_LIGHT_INTERVAL: light_interval_ff <= csr_data;
            CSR_SNAP_WINDOW:    snap_window_ff    <= csr_data;
            CSR_RAMP_STEP:      ramp_step_ff      <= csr_data;
            CSR_LIGHT_OFFSET:   light_offset_ff   <= csr_data[LIGHT_WIDTH-1:0];
            CSR_MIN_DIGIT_DUTY: min_duty_ff       <= csr_data;
            CSR_MAX_DIGIT_DUTY: max_duty_ff       <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

[sv/dbs_dot_wave.sv]
// Breathing waveform for the dot duty, computed from the millisecond stamp.
module dbs_dot_wave (
   input  logic [dbs_pkg::TIME_WIDTH-1:0] now_ms,
   output logic [dbs_pkg::DOT_WIDTH-1:0]  duty
);
   import dbs_pkg::*;

   logic [WAVE_PERIODS-1:0] above;
   logic [3:0]              periods;
   logic [TIME_WIDTH-1:0]   base;
   logic [13:0]             phase;
   logic [DOT_WIDTH-1:0]    rise;
   logic [DOT_WIDTH-1:0]    fall;

   always_comb begin
      for (int i = 0; i < WAVE_PERIODS; i++) begin
         above[i] = now_ms >= TIME_WIDTH'((i + 1) * WAVE_PERIOD);
      end
      periods = 4'($countones(above));
      base    = TIME_WIDTH'(periods * 17'd10000);
      phase   = 14'(now_ms - base);
      rise    = '0;
      fall    = '0;
      if (phase <= 14'd1000) begin
         rise = 16'(phase * 16'd40);
         duty = rise + 16'd10000;
      end else if (phase <= 14'd5000) begin
         fall = 16'((phase - 14'd1000) * 16'd10);
         duty = 16'd50000 - fall;
      end else if (phase <= 14'd6000) begin
         rise = 16'((phase - 14'd5000) * 16'd40);
         duty = rise + 16'd10000;
      end else begin
         fall = 16'((phase - 14'd6000) * 16'd10);
         duty = 16'd50000 - fall;
      end
   end

endmodule
